/* hdl/mtc_pkg.sv */
`default_nettype none

package mtc_pkg;

   localparam int SecondsWidth = 13;
   localparam int QuickWidth   = 8;
   localparam int FinishWidth  = 8;
   localparam int KeyWidth     = 4;
   localparam int DigitWidth   = 4;
   localparam int CsrIndexWidth = 2;

   localparam logic [SecondsWidth-1:0] SECONDS_CEIL = 13'd5999;
   localparam logic [QuickWidth-1:0]   QUICK_RESET  = 8'd30;
   localparam logic [FinishWidth-1:0]  FINISH_RESET = 8'd5;

   // floor(x * 34953 / 2^21) equals floor(x / 60) for x up to the ceiling
   localparam logic [15:0] MIN_RECIP   = 16'd34953;
   // floor(x * 205 / 2^11) equals floor(x / 10) for x below 100
   localparam logic [7:0]  TENTH_RECIP = 8'd205;

   localparam logic [KeyWidth-1:0] KEY_LAST_DIGIT = 4'd9;
   localparam logic [KeyWidth-1:0] KEY_A = 4'd10;
   localparam logic [KeyWidth-1:0] KEY_B = 4'd11;
   localparam logic [KeyWidth-1:0] KEY_C = 4'd12;
   localparam logic [KeyWidth-1:0] KEY_D = 4'd13;

   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_KEY  = 1'b1;

   typedef enum logic [2:0] {
      MODE_STANDBY  = 3'd0,
      MODE_ENTERING = 3'd1,
      MODE_COOKING  = 3'd2,
      MODE_PAUSED   = 3'd3,
      MODE_FINISHED = 3'd4
   } mtc_mode_type;

   typedef enum logic [2:0] {
      MSG_BLANK    = 3'd0,
      MSG_COOKING  = 3'd1,
      MSG_FINISHED = 3'd2,
      MSG_PAUSED   = 3'd3,
      MSG_DOOR     = 3'd4
   } mtc_msg_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_MAX_SECONDS  = 2'd0,
      CSR_QUICK_ADD    = 2'd1,
      CSR_FINISH_TICKS = 2'd2
   } mtc_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_EVAL,
      ST_CONV_Q,
      ST_CONV_R,
      ST_CONV_D,
      ST_DONE
   } mtc_state_type;

   typedef struct packed {
      logic load_item;
      logic prep;
      logic apply;
      logic conv_q;
      logic conv_r;
      logic conv_d;
      logic out_load;
   } mtc_cmd_type;

   typedef struct packed {
      logic conv_need;
      logic out_free;
   } mtc_status_type;

   function automatic logic [DigitWidth-1:0] tens_of(input logic [6:0] x);
      logic [14:0] p;
      p = 15'(x) * 15'(TENTH_RECIP);
      return p[14:11];
   endfunction

endpackage

`default_nettype wire

/* hdl/microwave_timer_controller.sv */
// Oven timer controller: one result transaction for every input transaction.
// Input channel (req_valid/req_ready): req_action 0 is a one-second tick,
// 1 a key press with req_key_code (digits, A start, B pause/cancel, C quick
// start or add, D door open). Result channel (rsp_valid/rsp_ready): mode,
// the four MM:SS digits, heater, turntable and alarm drives, message code,
// blank flag and remaining seconds, after the transaction is applied.
// A result goes through the prep, evaluate and done states of the sequencer;
// when the remaining time changes it also goes through the minutes/seconds
// conversion (one reciprocal multiply, one remainder step, one digit step).
// req_ready is high only while the sequencer is idle, so a new transaction
// is not taken until the last one has left the done state.
// The result sits in an output register: the next transaction is accepted
// while it waits, and its own result is held back until rsp_ready frees it.
// Reset (synchronous, active high) puts the oven in standby with zero time,
// all drives off, and loads the defaults 5999, 30 and 5 into the csr
// registers (0 ceiling, 1 quick-add seconds, 2 finished ticks). csr writes
// take effect at once and are expected only while the block is idle.
`default_nettype none

module microwave_timer_controller (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [mtc_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [mtc_pkg::SecondsWidth-1:0]  csr_write_data,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_action,
   input  wire logic [mtc_pkg::KeyWidth-1:0]      req_key_code,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [2:0]                             rsp_mode,
   output logic [mtc_pkg::DigitWidth-1:0]         rsp_minute_tens,
   output logic [mtc_pkg::DigitWidth-1:0]         rsp_minute_ones,
   output logic [mtc_pkg::DigitWidth-1:0]         rsp_second_tens,
   output logic [mtc_pkg::DigitWidth-1:0]         rsp_second_ones,
   output logic                                   rsp_heater_on,
   output logic                                   rsp_turntable_on,
   output logic                                   rsp_alarm_on,
   output logic [2:0]                             rsp_message,
   output logic                                   rsp_display_blank,
   output logic [mtc_pkg::SecondsWidth-1:0]       rsp_seconds_left
);
   import mtc_pkg::*;

   mtc_cmd_type    cmd;
   mtc_status_type status;

   mtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mtc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_action        (req_action),
      .req_key_code      (req_key_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mode          (rsp_mode),
      .rsp_minute_tens   (rsp_minute_tens),
      .rsp_minute_ones   (rsp_minute_ones),
      .rsp_second_tens   (rsp_second_tens),
      .rsp_second_ones   (rsp_second_ones),
      .rsp_heater_on     (rsp_heater_on),
      .rsp_turntable_on  (rsp_turntable_on),
      .rsp_alarm_on      (rsp_alarm_on),
      .rsp_message       (rsp_message),
      .rsp_display_blank (rsp_display_blank),
      .rsp_seconds_left  (rsp_seconds_left)
   );

   // one transaction in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while a transaction is in flight");

   // heater only while cooking, alarm only while finished
   a_drive_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((!rsp_heater_on || rsp_mode == MODE_COOKING) &&
                     (!rsp_alarm_on || rsp_mode == MODE_FINISHED)))
      else $error("drive output active in wrong mode");

   // standby result carries no time and no drives
   a_standby_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mode == MODE_STANDBY) |->
         (rsp_seconds_left == '0 && !rsp_turntable_on && !rsp_heater_on))
      else $error("standby result not cleared");

   // remaining time never above the hard ceiling
   a_time_ceiling: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_seconds_left <= SECONDS_CEIL)
      else $error("remaining time above ceiling");

endmodule

`default_nettype wire

/* hdl/mtc_ctrl.sv */
`default_nettype none

module mtc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire mtc_pkg::mtc_status_type status,
   output mtc_pkg::mtc_cmd_type        cmd
);
   import mtc_pkg::*;

   mtc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP:   state_in = ST_EVAL;
         ST_EVAL: begin
            state_in = status.conv_need ? ST_CONV_Q : ST_DONE;
         end
         ST_CONV_Q: state_in = ST_CONV_R;
         ST_CONV_R: state_in = ST_CONV_D;
         ST_CONV_D: state_in = ST_DONE;
         ST_DONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_PREP:   cmd.prep   = 1'b1;
         ST_EVAL:   cmd.apply  = 1'b1;
         ST_CONV_Q: cmd.conv_q = 1'b1;
         ST_CONV_R: cmd.conv_r = 1'b1;
         ST_CONV_D: cmd.conv_d = 1'b1;
         ST_DONE:   cmd.out_load = status.out_free;
         default:   cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

/* hdl/mtc_dp.sv */
`default_nettype none

module mtc_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire mtc_pkg::mtc_cmd_type                  cmd,
   output mtc_pkg::mtc_status_type                    status,
   input  wire logic                                  csr_write_enable,
   input  wire logic [mtc_pkg::CsrIndexWidth-1:0]     csr_index,
   input  wire logic [mtc_pkg::SecondsWidth-1:0]      csr_write_data,
   input  wire logic                                  req_action,
   input  wire logic [mtc_pkg::KeyWidth-1:0]          req_key_code,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [2:0]                                 rsp_mode,
   output logic [mtc_pkg::DigitWidth-1:0]             rsp_minute_tens,
   output logic [mtc_pkg::DigitWidth-1:0]             rsp_minute_ones,
   output logic [mtc_pkg::DigitWidth-1:0]             rsp_second_tens,
   output logic [mtc_pkg::DigitWidth-1:0]             rsp_second_ones,
   output logic                                       rsp_heater_on,
   output logic                                       rsp_turntable_on,
   output logic                                       rsp_alarm_on,
   output logic [2:0]                                 rsp_message,
   output logic                                       rsp_display_blank,
   output logic [mtc_pkg::SecondsWidth-1:0]           rsp_seconds_left
);
   import mtc_pkg::*;

   // configuration
   logic [SecondsWidth-1:0] max_ff;
   logic [QuickWidth-1:0]   quick_ff;
   logic [FinishWidth-1:0]  finish_ff;

   // held transaction
   logic                action_ff;
   logic [KeyWidth-1:0] key_ff;

   // controller state of the oven
   mtc_mode_type            mode_ff, mode_in;
   logic [DigitWidth-1:0]   digit_ff [4];
   logic [DigitWidth-1:0]   digit_in [4];
   logic [SecondsWidth-1:0] rem_ff, rem_in;
   logic [2:0]              cnt_ff, cnt_in;
   logic [FinishWidth-1:0]  fc_ff, fc_in;
   logic                    blink_ff, blink_in;
   logic [2:0]              drive_ff, drive_in;
   mtc_msg_type             msg_ff, msg_in;

   // working values
   logic [SecondsWidth-1:0] sum_ff, sum_in;
   logic [6:0]              quot_ff, quot_in;
   logic [5:0]              srem_ff, srem_in;
   logic [DigitWidth-1:0]   mtens_ff, mtens_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   mtc_mode_type            out_mode_ff;
   logic [DigitWidth-1:0]   out_digit_ff [4];
   logic [2:0]              out_drive_ff;
   mtc_msg_type             out_msg_ff;
   logic                    out_blank_ff;
   logic [SecondsWidth-1:0] out_rem_ff;

   logic [SecondsWidth-1:0] entry_mins, entry_val, base_val, add_val;
   logic [SecondsWidth-1:0] ceil_val, clamp_val, rem_dec;
   logic [FinishWidth-1:0]  fc_inc;
   logic                    is_key, is_digit, go_idle, conv_need;
   logic [28:0]             quot_prod;
   logic [SecondsWidth-1:0] srem_full;
   logic [6:0]              mones_full, sones_full;
   logic [DigitWidth-1:0]   stens_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff    <= SECONDS_CEIL;
         quick_ff  <= QUICK_RESET;
         finish_ff <= FINISH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_SECONDS:  max_ff    <= csr_write_data;
            CSR_QUICK_ADD:    quick_ff  <= csr_write_data[QuickWidth-1:0];
            CSR_FINISH_TICKS: finish_ff <= csr_write_data[FinishWidth-1:0];
            default: ;
         endcase
      end
   end

   // prep: operand for the add and clamp
   always_comb begin
      entry_mins = 13'(digit_ff[0]) * 13'(10) + 13'(digit_ff[1]);
      entry_val  = entry_mins * 13'(60) + 13'(digit_ff[2]) * 13'(10) + 13'(digit_ff[3]);
      case (mode_ff)
         MODE_ENTERING: base_val = entry_val;
         MODE_COOKING:  base_val = rem_ff;
         default:       base_val = '0;
      endcase
      add_val = (key_ff == KEY_C) ? 13'(quick_ff) : '0;
      sum_in  = base_val + add_val;
   end

   // conversion of the remaining time into MM:SS digits
   always_comb begin
      quot_prod  = 29'(rem_ff) * 29'(MIN_RECIP);
      quot_in    = quot_prod[27:21];
      srem_full  = rem_ff - 13'(quot_ff) * 13'(60);
      srem_in    = srem_full[5:0];
      mtens_in   = tens_of(quot_ff);
      mones_full = quot_ff - 7'(mtens_ff) * 7'(10);
      stens_w    = tens_of(7'(srem_ff));
      sones_full = 7'(srem_ff) - 7'(stens_w) * 7'(10);
   end

   always_comb begin
      ceil_val  = (max_ff > SECONDS_CEIL) ? SECONDS_CEIL : max_ff;
      clamp_val = (sum_ff > ceil_val) ? ceil_val : sum_ff;
      rem_dec   = rem_ff - 13'd1;
      fc_inc    = fc_ff + 8'd1;
      is_key    = (action_ff == ACTION_KEY);
      is_digit  = (key_ff <= KEY_LAST_DIGIT);

      mode_in   = mode_ff;
      digit_in  = digit_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      fc_in     = fc_ff;
      blink_in  = blink_ff;
      drive_in  = drive_ff;
      msg_in    = msg_ff;
      go_idle   = 1'b0;
      conv_need = 1'b0;

      if (cmd.apply) begin
         case (mode_ff)
            MODE_STANDBY: begin
               drive_in = '0;
               if (is_key && is_digit) begin
                  mode_in     = MODE_ENTERING;
                  digit_in[0] = '0;
                  digit_in[1] = '0;
                  digit_in[2] = '0;
                  digit_in[3] = key_ff;
                  cnt_in      = 3'd1;
               end else if (is_key && key_ff == KEY_C) begin
                  rem_in    = clamp_val;
                  conv_need = 1'b1;
                  mode_in   = MODE_COOKING;
                  drive_in  = 3'b011;
                  msg_in    = MSG_COOKING;
               end
            end
            MODE_ENTERING: begin
               if (is_key) begin
                  if (is_digit) begin
                     if (cnt_ff < 3'd4) begin
                        digit_in[0] = digit_ff[1];
                        digit_in[1] = digit_ff[2];
                        digit_in[2] = digit_ff[3];
                        digit_in[3] = key_ff;
                        cnt_in      = cnt_ff + 3'd1;
                     end
                  end else if (key_ff == KEY_B) begin
                     go_idle = 1'b1;
                  end else if (key_ff == KEY_A) begin
                     rem_in = clamp_val;
                     if (clamp_val != '0) begin
                        cnt_in    = '0;
                        conv_need = 1'b1;
                        mode_in   = MODE_COOKING;
                        drive_in  = 3'b011;
                        msg_in    = MSG_COOKING;
                     end
                  end else if (key_ff == KEY_C) begin
                     rem_in    = clamp_val;
                     conv_need = 1'b1;
                  end
               end
            end
            MODE_COOKING: begin
               if (!is_key) begin
                  if (rem_ff != '0) begin
                     rem_in    = rem_dec;
                     conv_need = 1'b1;
                  end
                  // count already at zero or just reached it
                  if (rem_ff <= 13'd1) begin
                     mode_in  = MODE_FINISHED;
                     drive_in = 3'b100;
                     fc_in    = '0;
                     blink_in = 1'b1;
                     msg_in   = MSG_FINISHED;
                  end
               end else if (key_ff == KEY_B) begin
                  mode_in     = MODE_PAUSED;
                  drive_in[0] = 1'b0;
                  msg_in      = MSG_PAUSED;
               end else if (key_ff == KEY_C) begin
                  rem_in    = clamp_val;
                  conv_need = 1'b1;
               end else if (key_ff == KEY_D) begin
                  mode_in       = MODE_PAUSED;
                  drive_in[1:0] = 2'b00;
                  msg_in        = MSG_DOOR;
               end
            end
            MODE_PAUSED: begin
               if (is_key && key_ff == KEY_A) begin
                  mode_in  = MODE_COOKING;
                  drive_in = 3'b011;
                  msg_in   = MSG_COOKING;
               end else if (is_key && key_ff == KEY_B) begin
                  go_idle = 1'b1;
               end
            end
            MODE_FINISHED: begin
               if (is_key) begin
                  go_idle = 1'b1;
               end else begin
                  fc_in       = fc_inc;
                  blink_in    = ~blink_ff;
                  drive_in[2] = ~blink_ff;
                  if (fc_inc >= finish_ff) go_idle = 1'b1;
               end
            end
            default: go_idle = 1'b1;
         endcase
      end

      if (go_idle) begin
         mode_in  = MODE_STANDBY;
         digit_in = '{default: '0};
         rem_in   = '0;
         cnt_in   = '0;
         fc_in    = '0;
         blink_in = 1'b1;
         drive_in = '0;
         msg_in   = MSG_BLANK;
      end

      if (cmd.conv_d) begin
         digit_in[0] = mtens_ff;
         digit_in[1] = mones_full[3:0];
         digit_in[2] = stens_w;
         digit_in[3] = sones_full[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_STANDBY;
         digit_ff     <= '{default: '0};
         rem_ff       <= '0;
         cnt_ff       <= '0;
         fc_ff        <= '0;
         blink_ff     <= 1'b1;
         drive_ff     <= '0;
         msg_ff       <= MSG_BLANK;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         digit_ff     <= digit_in;
         rem_ff       <= rem_in;
         cnt_ff       <= cnt_in;
         fc_ff        <= fc_in;
         blink_ff     <= blink_in;
         drive_ff     <= drive_in;
         msg_ff       <= msg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         action_ff <= req_action;
         key_ff    <= req_key_code;
      end
      if (cmd.prep) sum_ff <= sum_in;
      if (cmd.conv_q) quot_ff <= quot_in;
      if (cmd.conv_r) begin
         srem_ff  <= srem_in;
         mtens_ff <= mtens_in;
      end
      if (cmd.out_load) begin
         out_mode_ff  <= mode_ff;
         out_digit_ff <= digit_ff;
         out_drive_ff <= drive_ff;
         out_msg_ff   <= msg_ff;
         out_blank_ff <= ~blink_ff;
         out_rem_ff   <= rem_ff;
      end
   end

   always_comb begin
      rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_comb begin
      status.conv_need = conv_need;
      status.out_free  = ~rsp_valid_ff | rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mode          = out_mode_ff;
   assign rsp_minute_tens   = out_digit_ff[0];
   assign rsp_minute_ones   = out_digit_ff[1];
   assign rsp_second_tens   = out_digit_ff[2];
   assign rsp_second_ones   = out_digit_ff[3];
   assign rsp_heater_on     = out_drive_ff[0];
   assign rsp_turntable_on  = out_drive_ff[1];
   assign rsp_alarm_on      = out_drive_ff[2];
   assign rsp_message       = out_msg_ff;
   assign rsp_display_blank = out_blank_ff;
   assign rsp_seconds_left  = out_rem_ff;

endmodule

`default_nettype wire
